// ----- hdl/lhba_pkg.sv -----
// Shared constants and types for the linear-hashing bucket addresser.
// No dependencies; used by every module of the block.
package lhba_pkg;

  // Field widths
  localparam int KEY_W   = 32;
  localparam int FIELD_W = 12;
  localparam int BASE_W  = 13;
  localparam int ROUND_W = 4;

  // A level is base << round (plus one for the doubled level); this holds it.
  localparam int LEVEL_W = BASE_W + (1 << ROUND_W);

  // Result tdata: bucket, split_from, split_to, padded to whole bytes
  localparam int OUT_W   = ((3 * FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - 3 * FIELD_W;

  // Bit-serial step counter width
  localparam int STEP_W = $clog2(KEY_W + 1);

  localparam int MAX_BUCKETS_DEF = 4096;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(16);

  // Item kinds and result status codes
  localparam logic KIND_ADDR  = 1'b0;
  localparam logic KIND_SPLIT = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Remainder unit result
  typedef struct packed {
    logic [LEVEL_W-1:0] rem;
    logic               q_lsb;
  } mod_rsp_t;

  // Split answer from the table state
  typedef struct packed {
    logic [FIELD_W-1:0] split_from;
    logic [FIELD_W-1:0] split_to;
    logic               status;
  } split_rsp_t;

endpackage

// ----- hdl/linear_hash_bucket_addresser_top.sv -----
// Top level of the linear-hashing bucket addresser: item FSM and result register.
// Depends on lhba_pkg, lhba_serial_mod and lhba_table.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  s        | in  | s_tvalid / s_tready  | tdata: key[31:0]; tuser: kind
//  m        | out | m_tvalid / m_tready  | tdata: bucket, split_from, split_to; tuser: status
//  cfg      | in  | cfg_valid/cfg_ready  | cfg_data: base_buckets[12:0]
//
// Address item: after 32 one-bit remainder steps, done is seen (ST_DIV to ST_FIX) and the
// selected bucket is loaded into the result register; the next item is taken in ST_IDLE.
// Split item: the table answer is loaded into the result register from ST_SPLIT.
// One item at a time; a new item is taken while the last result still waits at m.
// Reset (rst, synchronous) restores base 16 and an empty split round.
// A stalled output holds the finishing item until the result register frees up.
module linear_hash_bucket_addresser_top #(
  parameter int MAX_BUCKETS = lhba_pkg::MAX_BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lhba_pkg::KEY_W-1:0]   s_tdata,   // [31:0] key
  input  logic                         s_tuser,   // [0] kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lhba_pkg::OUT_W-1:0]   m_tdata,   // [11:0] bucket, [23:12] split_from,
                                                  // [35:24] split_to, [39:36] zero
  output logic                         m_tuser,   // [0] status
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lhba_pkg::BASE_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_FIX   = 4'b0100,
    ST_SPLIT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic                         in_acc;
  logic                         out_free;
  logic                         mod_start;
  logic                         mod_done;
  lhba_pkg::mod_rsp_t           mod_rsp;
  logic                         split_go;
  lhba_pkg::split_rsp_t         split_rsp;
  logic [CNT_W-1:0]             ptr;
  logic [lhba_pkg::LEVEL_W-1:0] level;
  logic                         below_ptr;
  logic [lhba_pkg::FIELD_W-1:0] bucket;
  logic                         load_addr;
  logic                         load_split;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign mod_start = in_acc && (s_tuser == lhba_pkg::KIND_ADDR);

  assign load_addr  = (state == ST_FIX) && out_free;
  assign load_split = (state == ST_SPLIT) && out_free;
  assign split_go   = load_split;

  lhba_serial_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .key     (s_tdata),
    .divisor (level),
    .done    (mod_done),
    .rsp     (mod_rsp)
  );

  lhba_table #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .CNT_W       (CNT_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .split_go  (split_go),
    .ptr       (ptr),
    .level     (level),
    .split_rsp (split_rsp)
  );

  // Below the pointer the doubled level applies: add level back if quotient is odd
  assign below_ptr = mod_rsp.rem < lhba_pkg::LEVEL_W'(ptr);
  assign bucket    = mod_rsp.rem[lhba_pkg::FIELD_W-1:0] +
                     ((below_ptr && mod_rsp.q_lsb) ? level[lhba_pkg::FIELD_W-1:0] : '0);

  // Item sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc)
          state_next = (s_tuser == lhba_pkg::KIND_SPLIT) ? ST_SPLIT : ST_DIV;
      end
      ST_DIV: begin
        if (mod_done)
          state_next = ST_FIX;
      end
      ST_FIX: begin
        if (out_free)
          state_next = ST_IDLE;
      end
      ST_SPLIT: begin
        if (out_free)
          state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst)
      m_tvalid <= 1'b0;
    else if (load_addr || load_split)
      m_tvalid <= 1'b1;
    else if (m_tready)
      m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_addr) begin
      m_tdata <= {{lhba_pkg::OUT_PAD{1'b0}}, {lhba_pkg::FIELD_W{1'b0}},
                  {lhba_pkg::FIELD_W{1'b0}}, bucket};
      m_tuser <= lhba_pkg::STATUS_OK;
    end else if (load_split) begin
      m_tdata <= {{lhba_pkg::OUT_PAD{1'b0}}, split_rsp.split_to,
                  split_rsp.split_from, {lhba_pkg::FIELD_W{1'b0}}};
      m_tuser <= split_rsp.status;
    end
  end

`ifndef SYNTH
  // A refused split carries no bucket indexes
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lhba_pkg::STATUS_FULL) |-> m_tdata == '0)
    else $error("refused split with nonzero indexes");
`endif

endmodule

// ----- hdl/lhba_serial_mod.sv -----
// Bit-serial restoring remainder unit: key mod divisor, one key bit a cycle.
// Also returns the lowest quotient bit. Depends on lhba_pkg.
module lhba_serial_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lhba_pkg::KEY_W-1:0]    key,
  input  logic [lhba_pkg::LEVEL_W-1:0]  divisor,
  output logic                          done,
  output lhba_pkg::mod_rsp_t            rsp
);

  logic [lhba_pkg::KEY_W-1:0]   key_sr;
  logic [lhba_pkg::LEVEL_W-1:0] rem;
  logic [lhba_pkg::LEVEL_W-1:0] div;
  logic [lhba_pkg::STEP_W-1:0]  count;
  logic                         busy;
  logic                         q_lsb;

  logic [lhba_pkg::LEVEL_W:0] trial;
  logic [lhba_pkg::LEVEL_W:0] diff;
  logic                       ge;

  // One restoring step: shift in next key bit, subtract if it fits
  assign trial = {rem, key_sr[lhba_pkg::KEY_W-1]};
  assign ge    = trial >= {1'b0, div};
  assign diff  = trial - {1'b0, div};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= lhba_pkg::STEP_W'(lhba_pkg::KEY_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == lhba_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      key_sr <= key;
      rem    <= '0;
      div    <= divisor;
      q_lsb  <= 1'b0;
    end else if (busy) begin
      key_sr <= {key_sr[lhba_pkg::KEY_W-2:0], 1'b0};
      rem    <= ge ? diff[lhba_pkg::LEVEL_W-1:0] : trial[lhba_pkg::LEVEL_W-1:0];
      q_lsb  <= ge;
    end
  end

  assign rsp.rem   = rem;
  assign rsp.q_lsb = q_lsb;

`ifndef SYNTH
  // Partial remainder stays below the divisor while stepping
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> rem < div)
    else $error("remainder not below divisor");

  // Done is raised in the cycle after the last step, when busy has dropped
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a finishing step");
`endif

endmodule

// ----- hdl/lhba_table.sv -----
// Table state: base register, split pointer, round, used bucket count and level.
// Answers split items and restarts on a base write. Depends on lhba_pkg.
module lhba_table #(
  parameter int MAX_BUCKETS = lhba_pkg::MAX_BUCKETS_DEF,
  parameter int CNT_W       = $clog2(MAX_BUCKETS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lhba_pkg::BASE_W-1:0]   cfg_data,
  input  logic                          split_go,
  output logic [CNT_W-1:0]              ptr,
  output logic [lhba_pkg::LEVEL_W-1:0]  level,
  output lhba_pkg::split_rsp_t          split_rsp
);

  localparam int CMP_W = lhba_pkg::BASE_W + CNT_W + 1;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BUCKETS);

  logic [lhba_pkg::BASE_W-1:0]  base, base_next;
  logic [lhba_pkg::ROUND_W-1:0] round, round_next;
  logic [CNT_W-1:0]             used, used_next;
  logic [CNT_W-1:0]             ptr_next;
  logic [lhba_pkg::LEVEL_W-1:0] level_next;
  logic [CNT_W-1:0]             eff_next;
  logic [CNT_W:0]               ptr_inc;
  logic                         full;
  logic                         wrap;

  // Clamp a base value into 1..MAX_BUCKETS
  function automatic logic [CNT_W-1:0] clamp_base(input logic [lhba_pkg::BASE_W-1:0] b);
    logic [CMP_W-1:0] bx;
    bx = CMP_W'(b);
    if (bx == '0)
      bx = CMP_W'(1);
    if (bx > CMP_W'(MAX_BUCKETS))
      bx = CMP_W'(MAX_BUCKETS);
    return bx[CNT_W-1:0];
  endfunction

  assign full    = used >= MAX_C;
  assign ptr_inc = {1'b0, ptr} + 1'b1;
  assign wrap    = lhba_pkg::LEVEL_W'(ptr_inc) >= level;

  // Next-state selection: reset, restart on base write, split, hold
  always_comb begin
    base_next  = base;
    round_next = round;
    used_next  = used;
    ptr_next   = ptr;
    if (rst || cfg_we) begin
      base_next  = rst ? lhba_pkg::BASE_RESET : cfg_data;
      round_next = '0;
      ptr_next   = '0;
      used_next  = clamp_base(base_next);
    end else if (split_go && !full) begin
      used_next = used + 1'b1;
      if (wrap) begin
        ptr_next   = '0;
        round_next = round + 1'b1;
      end else begin
        ptr_next = ptr_inc[CNT_W-1:0];
      end
    end
    eff_next   = clamp_base(base_next);
    level_next = lhba_pkg::LEVEL_W'(eff_next) << round_next;
  end

  always_ff @(posedge clk) begin
    base  <= base_next;
    round <= round_next;
    used  <= used_next;
    ptr   <= ptr_next;
    level <= level_next;
  end

  // Split answer for the current state
  always_comb begin
    if (full) begin
      split_rsp.split_from = '0;
      split_rsp.split_to   = '0;
      split_rsp.status     = lhba_pkg::STATUS_FULL;
    end else begin
      split_rsp.split_from = lhba_pkg::FIELD_W'(ptr);
      split_rsp.split_to   = lhba_pkg::FIELD_W'(used);
      split_rsp.status     = lhba_pkg::STATUS_OK;
    end
  end

`ifndef SYNTH
  // The split pointer always lies inside the current level
  a_ptr_in_level: assert property (@(posedge clk) disable iff (rst)
    lhba_pkg::LEVEL_W'(ptr) < level)
    else $error("split pointer beyond level");

  // Bucket count never passes capacity
  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used <= MAX_C)
    else $error("used buckets beyond capacity");

  // A refused split leaves the pointer alone
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    split_go && full && !cfg_we |=> $stable(ptr))
    else $error("refused split moved the pointer");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for linear_hash_bucket_addresser_top.
// Depends on lhba_pkg and the addresser RTL; a built-in table model predicts each result.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 2000;  // cycles without any handshake before giving up
  localparam int SETTLE     = 40;    // a little more than the address latency

  typedef struct packed {
    logic [lhba_pkg::FIELD_W-1:0] bucket;
    logic [lhba_pkg::FIELD_W-1:0] split_from;
    logic [lhba_pkg::FIELD_W-1:0] split_to;
    logic                         status;
  } hash_result_t;

  // Table model: split pointer, round and bucket count, plus the results still owed
  class lh_table_model;
    int unsigned base_eff;
    int unsigned pointer;
    int unsigned round;
    int unsigned used;
    int unsigned errors;
    hash_result_t owed_q[$];

    function new();
      errors = 0;
      restart(lhba_pkg::BASE_RESET);
    endfunction

    // A base write restarts the table; base is clamped to 1..capacity
    function void restart(logic [lhba_pkg::BASE_W-1:0] value);
      base_eff = (value == 0) ? 1 : value;
      if (base_eff > lhba_pkg::MAX_BUCKETS_DEF) base_eff = lhba_pkg::MAX_BUCKETS_DEF;
      pointer = 0;
      round   = 0;
      used    = base_eff;
    endfunction

    function void note_item(logic kind, logic [lhba_pkg::KEY_W-1:0] key);
      hash_result_t r;
      longint unsigned span;
      longint unsigned idx;
      r = '0;
      if (kind == lhba_pkg::KIND_ADDR) begin
        span = longint'(base_eff) << round;
        idx  = key % span;
        // buckets below the pointer are already split: use the doubled level
        if (idx < pointer) idx = key % (span << 1);
        r.bucket = idx[lhba_pkg::FIELD_W-1:0];
      end else if (used >= lhba_pkg::MAX_BUCKETS_DEF) begin
        r.status = lhba_pkg::STATUS_FULL;
      end else begin
        r.split_from = lhba_pkg::FIELD_W'(pointer);
        r.split_to   = lhba_pkg::FIELD_W'(used);
        used    = used + 1;
        pointer = pointer + 1;
        if (pointer >= (base_eff << round)) begin
          pointer = 0;
          round   = (round + 1) & 15;
        end
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [lhba_pkg::FIELD_W-1:0] bucket,
                               logic [lhba_pkg::FIELD_W-1:0] from,
                               logic [lhba_pkg::FIELD_W-1:0] to, logic status);
      hash_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: bucket=%0d from=%0d to=%0d status=%0d",
                   bucket, from, to, status);
        return;
      end
      want = owed_q.pop_front();
      if (bucket !== want.bucket || from !== want.split_from ||
          to !== want.split_to || status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: exp bucket=%0d from=%0d to=%0d status=%0d,",
                    " got bucket=%0d from=%0d to=%0d status=%0d"},
                   want.bucket, want.split_from, want.split_to, want.status,
                   bucket, from, to, status);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [lhba_pkg::KEY_W-1:0]   s_tdata   = '0;
  logic                         s_tuser   = lhba_pkg::KIND_ADDR;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b1;
  logic [lhba_pkg::OUT_W-1:0]   m_tdata;
  logic                         m_tuser;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lhba_pkg::BASE_W-1:0]  cfg_data  = '0;

  bit                 bursts_on = 1'b1;
  int                 quiet_cycles = 0;
  lh_table_model      board;

  linear_hash_bucket_addresser_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata[lhba_pkg::FIELD_W-1:0],
                         m_tdata[2*lhba_pkg::FIELD_W-1:lhba_pkg::FIELD_W],
                         m_tdata[3*lhba_pkg::FIELD_W-1:2*lhba_pkg::FIELD_W], m_tuser);
  end

  // Receiver backpressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one item, with an optional gap first, and hold it until taken
  task automatic send_item(logic kind, logic [lhba_pkg::KEY_W-1:0] key);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    board.note_item(kind, key);
  endtask

  // Stop sending and wait for every owed result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_base(logic [lhba_pkg::BASE_W-1:0] value);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.restart(value);
  endtask

  // Keys: mostly full range, some small ones near bucket boundaries, some extremes
  function automatic logic [lhba_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 16383);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(int unsigned count, int unsigned split_pct);
    logic kind;
    for (int unsigned i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < split_pct) ? lhba_pkg::KIND_SPLIT
                                                 : lhba_pkg::KIND_ADDR;
      send_item(kind, pick_key());
      if (bursts_on && $urandom_range(0, 149) == 0) drain_results();
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset base: key extremes, a few splits, then keys on both sides of the pointer
    send_item(lhba_pkg::KIND_ADDR, 32'h0000_0000);
    send_item(lhba_pkg::KIND_ADDR, 32'hFFFF_FFFF);
    send_item(lhba_pkg::KIND_ADDR, 32'h0000_000F);
    send_item(lhba_pkg::KIND_ADDR, 32'h0000_0010);
    send_item(lhba_pkg::KIND_ADDR, 32'h8000_0000);
    send_item(lhba_pkg::KIND_ADDR, 32'h7FFF_FFFF);
    send_item(lhba_pkg::KIND_ADDR, 32'h5555_5555);
    send_item(lhba_pkg::KIND_ADDR, 32'hAAAA_AAAA);
    send_item(lhba_pkg::KIND_SPLIT, 32'hFFFF_FFFF);
    send_item(lhba_pkg::KIND_SPLIT, 32'h0000_0000);
    send_item(lhba_pkg::KIND_SPLIT, 32'h1234_5678);
    send_item(lhba_pkg::KIND_ADDR, 32'h0000_0020);
    send_item(lhba_pkg::KIND_ADDR, 32'h0000_0012);
    send_item(lhba_pkg::KIND_ADDR, 32'h0000_0013);
    send_item(lhba_pkg::KIND_ADDR, 32'hFFFF_FFFF);

    // Base of zero acts as one: the first split already wraps the pointer
    write_base('0);
    send_item(lhba_pkg::KIND_SPLIT, 32'h0);
    send_item(lhba_pkg::KIND_SPLIT, 32'h0);
    send_item(lhba_pkg::KIND_ADDR, 32'hFFFF_FFFF);
    send_item(lhba_pkg::KIND_SPLIT, 32'h0);
    send_item(lhba_pkg::KIND_ADDR, 32'h0000_0005);
    run_phase(200, 50);

    // Base above capacity is clamped: every split is refused
    write_base('1);
    send_item(lhba_pkg::KIND_SPLIT, 32'h0);
    send_item(lhba_pkg::KIND_ADDR, 32'hFFFF_FFFF);
    run_phase(100, 30);

    // Base exactly at capacity
    write_base(lhba_pkg::BASE_W'(lhba_pkg::MAX_BUCKETS_DEF));
    send_item(lhba_pkg::KIND_SPLIT, 32'h0);
    send_item(lhba_pkg::KIND_ADDR, 32'hDEAD_BEEF);
    run_phase(100, 30);

    // Close to capacity: the table fills within the phase
    write_base(lhba_pkg::BASE_W'(4000));
    run_phase(220, 50);

    write_base(lhba_pkg::BASE_W'($urandom_range(2, 64)));
    run_phase(200, 30);

    write_base(lhba_pkg::BASE_W'(1));
    run_phase(200, 40);

    write_base(lhba_pkg::BASE_W'($urandom_range(0, 8191)));
    run_phase(150, 30);

    // Last part at full rate on both sides
    write_base(lhba_pkg::BASE_W'(4090));
    bursts_on = 1'b0;
    run_phase(150, 40);

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- linear_hash_bucket_addresser_top.f -----
hdl/lhba_pkg.sv
hdl/lhba_serial_mod.sv
hdl/lhba_table.sv
hdl/linear_hash_bucket_addresser_top.sv
verif/tb.sv
